// ===== rtl/core/lfbd_pkg.sv =====
// -----------------------------------------------------------------------------
// lfbd_pkg
// shared types and codes of the laser frame blank/decimate core
// -----------------------------------------------------------------------------
package lfbd_pkg;

	localparam int unsigned ColW    = 8;
	localparam int unsigned PointW  = 6 * ColW;
	localparam int unsigned RidxW   = 9;
	localparam int unsigned TotalW  = 13;
	localparam int unsigned CfgIdxW = 2;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_END   = 2'd1,
		MODE_FETCH = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_POINT    = 3'd0,
		ST_READY    = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_STUCK    = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_JUMP_THRESHOLD = 2'd0,
		REG_BASE_DISTANCE  = 2'd1
	} reg_idx_t;

	// write enables toward the point and keep-mark memories, and the keep-mark write data
	typedef struct packed {
		logic pt_we;
		logic mk_we;
		logic mk_wdata;
	} store_req_t;

	function automatic logic [ColW-1:0] absdiff(input logic [ColW-1:0] a,
			input logic [ColW-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

endpackage

// ===== rtl/core/laser_frame_blank_decimate_core.sv =====
// -----------------------------------------------------------------------------
// laser_frame_blank_decimate_core
// loads colour points, inserts blanked midpoints, reduces and reads out a frame
// -----------------------------------------------------------------------------
// One item at a time. A load stores its point, with a blanked midpoint stored
// first when one is needed; a fetch reads through state S_FETCH; an empty or
// repeated end of frame answers from the idle state. A reducing end of frame
// runs passes over the point memory, whose single registered read port sets
// the pace: a ratio pass finds the ratio by subtraction, then compacts the
// stored points; a distance pass makes a backward marking walk and a forward
// compaction walk. The memory holds no reset; no clearing pass.
module laser_frame_blank_decimate_core #(
	parameter int unsigned MAX_POINTS   = 4096,
	parameter int unsigned FRAME_POINTS = 270
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        mode,
	input  logic [7:0]                        x,
	input  logic [7:0]                        y,
	input  logic [7:0]                        red,
	input  logic [7:0]                        gray,
	input  logic [7:0]                        blue,
	input  logic [7:0]                        green,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        status,
	output logic [7:0]                        out_x,
	output logic [7:0]                        out_y,
	output logic [7:0]                        out_red,
	output logic [7:0]                        out_gray,
	output logic [7:0]                        out_blue,
	output logic [7:0]                        out_green,
	output logic                              last_point,
	output logic [12:0]                       loaded_total,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lfbd_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [7:0]                        cfg_data
);

	localparam int unsigned CW = $clog2(MAX_POINTS + 1);
	localparam int unsigned AW = $clog2(MAX_POINTS);
	localparam int unsigned PW = lfbd_pkg::PointW;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD2, S_FETCH, S_SEL, S_DIV, S_RRD, S_RWR,
		S_DRD_LAST, S_DLAST, S_DRD, S_DWR, S_CRD, S_CWR, S_END
	} state_t;

	state_t                state_q;
	logic [7:0]            jt_q, bd_q, prev_x_q, prev_y_q, pass_q, lx_q, ly_q;
	logic [CW-1:0]         cnt_q, snap_q, i_q, w_q, m_q, ratio_q, rem_q;
	logic [lfbd_pkg::RidxW-1:0] ridx_q;
	logic                  ready_q;
	logic [PW-1:0]         pt_q;
	logic                  ovalid_q, olast_q;
	lfbd_pkg::status_t     ostat_q;
	logic [PW-1:0]         opt_q;
	logic [lfbd_pkg::TotalW-1:0] ototal_q;

	logic                  acc;
	logic [CW-1:0]         eff_cnt, fetch_idx, cnt_m1;
	logic                  mid, ovf;
	logic [8:0]            sum_x, sum_y, limit;
	logic [PW-1:0]         in_pt, mid_pt, rdata, wdata;
	logic                  rmark, blank, close, rdrop;
	logic [AW-1:0]         waddr, raddr;
	lfbd_pkg::store_req_t  req;
	logic [lfbd_pkg::RidxW:0] ridx_p1;

	assign in_stall  = (state_q != S_IDLE) || (ovalid_q && out_stall);
	assign acc       = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign eff_cnt = ready_q ? '0 : cnt_q;
	assign cnt_m1  = cnt_q - 1'b1;
	assign mid     = (eff_cnt != '0) &&
		((lfbd_pkg::absdiff(x, prev_x_q) > jt_q) || (lfbd_pkg::absdiff(y, prev_y_q) > jt_q));
	assign ovf     = ({1'b0, eff_cnt} + (mid ? (CW+1)'(2) : (CW+1)'(1))) >
		(CW+1)'(MAX_POINTS);
	assign sum_x   = {1'b0, x} + {1'b0, prev_x_q};
	assign sum_y   = {1'b0, y} + {1'b0, prev_y_q};
	assign in_pt   = {x, y, red, gray, blue, green};
	assign mid_pt  = {sum_x[8:1], sum_y[8:1], 32'd0};

	assign fetch_idx = (CW'(ridx_q) < cnt_q) ? CW'(ridx_q) : cnt_m1;
	assign ridx_p1   = {1'b0, ridx_q} + 1'b1;

	assign blank = (rdata[31:0] == 32'd0);
	assign limit = {1'b0, bd_q} + {1'b0, pass_q};
	assign close = ({1'b0, lfbd_pkg::absdiff(rdata[47:40], lx_q)} < limit) &&
		({1'b0, lfbd_pkg::absdiff(rdata[39:32], ly_q)} < limit);
	assign rdrop = !blank && (i_q != cnt_m1) && (m_q == '0);

	assign raddr = (state_q == S_IDLE) ? fetch_idx[AW-1:0] : i_q[AW-1:0];

	always_comb begin
		req   = '0;
		waddr = i_q[AW-1:0];
		wdata = rdata;
		case (state_q)
			S_IDLE: begin
				waddr      = eff_cnt[AW-1:0];
				wdata      = mid ? mid_pt : in_pt;
				req.pt_we  = acc && (mode == lfbd_pkg::MODE_LOAD) && !ovf;
			end
			S_LOAD2: begin
				waddr     = cnt_q[AW-1:0];
				wdata     = pt_q;
				req.pt_we = 1'b1;
			end
			S_RWR: begin
				waddr     = w_q[AW-1:0];
				req.pt_we = !rdrop;
			end
			S_CWR: begin
				waddr     = w_q[AW-1:0];
				req.pt_we = rmark;
			end
			S_DLAST: begin
				req.mk_we    = 1'b1;
				req.mk_wdata = 1'b1;
			end
			S_DWR: begin
				req.mk_we    = 1'b1;
				req.mk_wdata = blank || !close;
			end
			default: ;
		endcase
	end

	lfbd_store #(.Depth(MAX_POINTS), .AW(AW)) u_store (
		.clk   (clk),
		.req   (req),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata),
		.rmark (rmark)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			jt_q     <= 8'd25;
			bd_q     <= 8'd3;
			prev_x_q <= '0;
			prev_y_q <= '0;
			cnt_q    <= '0;
			snap_q   <= '0;
			pass_q   <= '0;
			ridx_q   <= '0;
			ready_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					lfbd_pkg::REG_JUMP_THRESHOLD: jt_q <= cfg_data;
					lfbd_pkg::REG_BASE_DISTANCE:  bd_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (mode)
							lfbd_pkg::MODE_LOAD: begin
								ready_q <= 1'b0;
								ridx_q  <= '0;
								if (ovf) begin
									cnt_q    <= eff_cnt;
									ovalid_q <= 1'b1;
									ostat_q  <= lfbd_pkg::ST_OVERFLOW;
									opt_q    <= '0;
									olast_q  <= 1'b0;
									ototal_q <= lfbd_pkg::TotalW'(eff_cnt);
								end else begin
									cnt_q    <= eff_cnt + 1'b1;
									prev_x_q <= x;
									prev_y_q <= y;
									pt_q     <= in_pt;
									if (mid) begin
										state_q <= S_LOAD2;
									end
								end
							end
							lfbd_pkg::MODE_END: begin
								if (ready_q) begin
									ridx_q   <= '0;
									ovalid_q <= 1'b1;
									ostat_q  <= lfbd_pkg::ST_READY;
									opt_q    <= '0;
									olast_q  <= 1'b0;
									ototal_q <= lfbd_pkg::TotalW'(snap_q);
								end else if (cnt_q == '0) begin
									ovalid_q <= 1'b1;
									ostat_q  <= lfbd_pkg::ST_EMPTY;
									opt_q    <= '0;
									olast_q  <= 1'b0;
									ototal_q <= '0;
								end else begin
									snap_q  <= cnt_q;
									pass_q  <= '0;
									state_q <= S_SEL;
								end
							end
							lfbd_pkg::MODE_FETCH: begin
								if (ready_q && cnt_q != '0) begin
									state_q <= S_FETCH;
								end
							end
							default: ;
						endcase
					end
				end
				S_LOAD2: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_IDLE;
				end
				S_FETCH: begin
					ovalid_q <= 1'b1;
					ostat_q  <= lfbd_pkg::ST_POINT;
					opt_q    <= rdata;
					ototal_q <= lfbd_pkg::TotalW'(snap_q);
					olast_q  <= (ridx_p1 >= (lfbd_pkg::RidxW+1)'(FRAME_POINTS));
					if (ridx_p1 >= (lfbd_pkg::RidxW+1)'(FRAME_POINTS)) begin
						ready_q <= 1'b0;
						cnt_q   <= '0;
						ridx_q  <= '0;
					end else begin
						ridx_q <= ridx_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_SEL: begin
					if ({1'b0, cnt_q} > (CW+1)'(2 * FRAME_POINTS)) begin
						rem_q   <= cnt_q;
						ratio_q <= '0;
						state_q <= S_DIV;
					end else begin
						i_q     <= cnt_m1;
						state_q <= S_DRD_LAST;
					end
				end
				// ratio by repeated subtraction of the frame size
				S_DIV: begin
					if ({1'b0, rem_q} >= (CW+1)'(FRAME_POINTS)) begin
						rem_q   <= rem_q - CW'(FRAME_POINTS);
						ratio_q <= ratio_q + 1'b1;
					end else begin
						if (ratio_q == '0) begin
							ratio_q <= CW'(1);
						end
						i_q     <= '0;
						w_q     <= '0;
						m_q     <= '0;
						state_q <= S_RRD;
					end
				end
				S_RRD: state_q <= S_RWR;
				S_RWR: begin
					if (!rdrop) begin
						w_q <= w_q + 1'b1;
					end
					m_q <= (m_q + 1'b1 == ratio_q) ? '0 : m_q + 1'b1;
					if (i_q == cnt_m1) begin
						state_q <= S_END;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_RRD;
					end
				end
				S_DRD_LAST: state_q <= S_DLAST;
				S_DLAST: begin
					lx_q <= rdata[47:40];
					ly_q <= rdata[39:32];
					if (i_q == '0) begin
						w_q     <= '0;
						state_q <= S_CRD;
					end else begin
						i_q     <= i_q - 1'b1;
						state_q <= S_DRD;
					end
				end
				S_DRD: state_q <= S_DWR;
				S_DWR: begin
					if (!blank && !close) begin
						lx_q <= rdata[47:40];
						ly_q <= rdata[39:32];
					end
					if (i_q == '0) begin
						w_q     <= '0;
						state_q <= S_CRD;
					end else begin
						i_q     <= i_q - 1'b1;
						state_q <= S_DRD;
					end
				end
				S_CRD: state_q <= S_CWR;
				S_CWR: begin
					if (rmark) begin
						w_q <= w_q + 1'b1;
					end
					if (i_q == cnt_m1) begin
						state_q <= S_END;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_CRD;
					end
				end
				S_END: begin
					if (pass_q != 8'hFF) begin
						pass_q <= pass_q + 1'b1;
					end
					if (w_q == cnt_q && {1'b0, w_q} > (CW+1)'(FRAME_POINTS)) begin
						cnt_q    <= '0;
						ovalid_q <= 1'b1;
						ostat_q  <= lfbd_pkg::ST_STUCK;
						opt_q    <= '0;
						olast_q  <= 1'b0;
						ototal_q <= lfbd_pkg::TotalW'(snap_q);
						state_q  <= S_IDLE;
					end else begin
						cnt_q <= w_q;
						if ({1'b0, w_q} > (CW+1)'(FRAME_POINTS)) begin
							state_q <= S_SEL;
						end else begin
							ready_q  <= 1'b1;
							ridx_q   <= '0;
							ovalid_q <= 1'b1;
							ostat_q  <= lfbd_pkg::ST_READY;
							opt_q    <= '0;
							olast_q  <= 1'b0;
							ototal_q <= lfbd_pkg::TotalW'(snap_q);
							state_q  <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = ovalid_q;
	assign status       = ostat_q;
	assign out_x        = opt_q[47:40];
	assign out_y        = opt_q[39:32];
	assign out_red      = opt_q[31:24];
	assign out_gray     = opt_q[23:16];
	assign out_blue     = opt_q[15:8];
	assign out_green    = opt_q[7:0];
	assign last_point   = olast_q;
	assign loaded_total = ototal_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cnt_q} <= (CW+1)'(MAX_POINTS))
		else $error("stored count beyond memory depth");

	a_ready_size: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (cnt_q != '0) && ({1'b0, cnt_q} <= (CW+1)'(FRAME_POINTS)))
		else $error("ready frame has bad size");

	a_last_is_point: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_point) |-> (status == lfbd_pkg::ST_POINT))
		else $error("last flag on a non-point item");
`endif

endmodule

// ===== rtl/core/lfbd_store.sv =====
// -----------------------------------------------------------------------------
// lfbd_store
// frame point memory and keep-mark memory, one write and one registered read
// -----------------------------------------------------------------------------
module lfbd_store #(
	parameter int unsigned Depth = 4096,
	parameter int unsigned AW    = 12
) (
	input  logic                          clk,
	input  lfbd_pkg::store_req_t          req,
	input  logic [AW-1:0]                 waddr,
	input  logic [lfbd_pkg::PointW-1:0]   wdata,
	input  logic [AW-1:0]                 raddr,
	output logic [lfbd_pkg::PointW-1:0]   rdata,
	output logic                          rmark
);

	logic [lfbd_pkg::PointW-1:0] pt_mem [Depth];
	logic                        mk_mem [Depth];

	always_ff @(posedge clk) begin
		if (req.pt_we) begin
			pt_mem[waddr] <= wdata;
		end
		rdata <= pt_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (req.mk_we) begin
			mk_mem[waddr] <= req.mk_wdata;
		end
		rmark <= mk_mem[raddr];
	end

endmodule

// ===== sim/lfbd_checker.sv =====
// -----------------------------------------------------------------------------
// lfbd_checker
// watches the item, result and register channels of the frame core, predicts
// every result from its own copy of the frame state and compares field by field
// -----------------------------------------------------------------------------
module lfbd_checker #(
	parameter int unsigned MAX_POINTS   = 4096,
	parameter int unsigned FRAME_POINTS = 270
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [1:0]                    mode,
	input  logic [7:0]                    x,
	input  logic [7:0]                    y,
	input  logic [7:0]                    red,
	input  logic [7:0]                    gray,
	input  logic [7:0]                    blue,
	input  logic [7:0]                    green,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [2:0]                    status,
	input  logic [7:0]                    out_x,
	input  logic [7:0]                    out_y,
	input  logic [7:0]                    out_red,
	input  logic [7:0]                    out_gray,
	input  logic [7:0]                    out_blue,
	input  logic [7:0]                    out_green,
	input  logic                          last_point,
	input  logic [12:0]                   loaded_total,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [lfbd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [7:0]                    cfg_data,
	output int                            fail_count,
	output int                            pending
);

	typedef struct {
		lfbd_pkg::status_t st;
		logic [7:0]  px;
		logic [7:0]  py;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  gr;
		logic        last;
		logic [12:0] total;
	} frame_result_t;

	frame_result_t expected_results[$];

	logic [7:0]  jump_thr;
	logic [7:0]  close_base;
	logic [47:0] pts [0:MAX_POINTS-1];
	logic        keep [0:MAX_POINTS-1];
	logic [7:0]  prev_x, prev_y;
	int          count;
	int          snapshot;
	int          passes;
	int          read_pos;
	bit          ready;

	assign pending = expected_results.size();

	function automatic int gap(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	task automatic expect_result(input frame_result_t e);
		expected_results = {expected_results, e};
	endtask

	task automatic squeeze(output int removed);
		int w;
		w = 0;
		for (int i = 0; i < count; i++) begin
			if (keep[i]) begin
				pts[w] = pts[i];
				w++;
			end
		end
		removed = count - w;
		count = w;
	endtask

	task automatic thin_by_ratio(output int removed);
		int ratio;
		ratio = count / FRAME_POINTS;
		if (ratio == 0) ratio = 1;
		for (int i = 0; i < count; i++)
			keep[i] = !(pts[i][31:0] != 0 && i + 1 != count && i % ratio == 0);
		squeeze(removed);
	endtask

	task automatic thin_by_distance(output int removed);
		int lim;
		logic [7:0] lx, ly;
		lim = int'(close_base) + passes;
		lx = pts[count-1][47:40];
		ly = pts[count-1][39:32];
		for (int i = count - 1; i >= 0; i--) begin
			keep[i] = 1'b1;
			if (pts[i][31:0] != 0 && i != count - 1) begin
				if (gap(pts[i][47:40], lx) < lim && gap(pts[i][39:32], ly) < lim) begin
					keep[i] = 1'b0;
				end else begin
					lx = pts[i][47:40];
					ly = pts[i][39:32];
				end
			end
		end
		squeeze(removed);
	endtask

	task automatic close_frame(output lfbd_pkg::status_t st);
		int removed;
		if (ready) begin
			read_pos = 0;
			st = lfbd_pkg::ST_READY;
			return;
		end
		if (count == 0) begin
			st = lfbd_pkg::ST_EMPTY;
			return;
		end
		snapshot = count;
		passes = 0;
		do begin
			if (count > 2 * FRAME_POINTS) thin_by_ratio(removed);
			else thin_by_distance(removed);
			if (passes < 255) passes++;
			if (removed == 0 && count > FRAME_POINTS) begin
				count = 0;
				st = lfbd_pkg::ST_STUCK;
				return;
			end
		end while (count > FRAME_POINTS);
		ready = 1'b1;
		read_pos = 0;
		st = lfbd_pkg::ST_READY;
	endtask

	task automatic predict_item();
		frame_result_t e;
		lfbd_pkg::status_t st;
		bit mid;
		int idx;
		logic [47:0] p;
		e = '{st: lfbd_pkg::ST_POINT, px: 0, py: 0, r: 0, g: 0, b: 0, gr: 0, last: 0,
			total: 0};
		case (lfbd_pkg::mode_t'(mode))
			lfbd_pkg::MODE_LOAD: begin
				if (ready) begin
					ready = 1'b0;
					count = 0;
					read_pos = 0;
				end
				mid = count > 0 && (gap(x, prev_x) > jump_thr || gap(y, prev_y) > jump_thr);
				if (count + (mid ? 2 : 1) > MAX_POINTS) begin
					e.st = lfbd_pkg::ST_OVERFLOW;
					e.total = 13'(count);
					expect_result(e);
				end else begin
					if (mid) begin
						pts[count] = {8'((int'(x) + int'(prev_x)) >> 1),
							8'((int'(y) + int'(prev_y)) >> 1), 32'd0};
						count++;
					end
					pts[count] = {x, y, red, gray, blue, green};
					count++;
					prev_x = x;
					prev_y = y;
				end
			end
			lfbd_pkg::MODE_END: begin
				close_frame(st);
				e.st = st;
				e.total = (st == lfbd_pkg::ST_EMPTY) ? 13'd0 : 13'(snapshot);
				expect_result(e);
			end
			lfbd_pkg::MODE_FETCH: begin
				if (ready && count != 0) begin
					idx = (read_pos < count) ? read_pos : count - 1;
					p = pts[idx];
					{e.px, e.py, e.r, e.g, e.b, e.gr} = p;
					e.last = (read_pos + 1 >= FRAME_POINTS);
					e.total = 13'(snapshot);
					expect_result(e);
					if (e.last) begin
						ready = 1'b0;
						count = 0;
						read_pos = 0;
					end else begin
						read_pos = (read_pos + 1) % 512;
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_result_t e;
		if (!arst_n) begin
			jump_thr = 8'd25;
			close_base = 8'd3;
			prev_x = 0;
			prev_y = 0;
			count = 0;
			snapshot = 0;
			passes = 0;
			read_pos = 0;
			ready = 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (lfbd_pkg::reg_idx_t'(cfg_index))
					lfbd_pkg::REG_JUMP_THRESHOLD: jump_thr = cfg_data;
					lfbd_pkg::REG_BASE_DISTANCE:  close_base = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with none expected, status %0d", $time, status);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					check_field("status", e.st, status);
					check_field("out_x", e.px, out_x);
					check_field("out_y", e.py, out_y);
					check_field("out_red", e.r, out_red);
					check_field("out_gray", e.g, out_gray);
					check_field("out_blue", e.b, out_blue);
					check_field("out_green", e.gr, out_green);
					check_field("last_point", e.last, last_point);
					check_field("loaded_total", e.total, loaded_total);
				end
			end
			if (in_valid && !in_stall) predict_item();
		end
	end

	initial fail_count = 0;

endmodule

// ===== sim/tb.sv =====
// -----------------------------------------------------------------------------
// tb
// drives directed and random frames into the frame core with bursty input,
// patterned output stalls and register changes between frames
// -----------------------------------------------------------------------------
module tb;

	localparam int FRAME_POINTS = 270;
	localparam int ITEMS = 1950;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = lfbd_pkg::MODE_NONE;
	logic [7:0] x = 0, y = 0, red = 0, gray = 0, blue = 0, green = 0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [7:0] out_x, out_y, out_red, out_gray, out_blue, out_green;
	logic last_point;
	logic [12:0] loaded_total;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [lfbd_pkg::CfgIdxW-1:0] cfg_index = lfbd_pkg::REG_JUMP_THRESHOLD;
	logic [7:0] cfg_data = 0;
	int fail_count;
	int pending;

	int items_sent = 0;
	int burst_left = 0;
	logic [7:0] walk_x = 0, walk_y = 0;
	int step_span = 3;
	int blank_pct = 20;

	always #5 clk = ~clk;

	laser_frame_blank_decimate_core dut (.*);

	lfbd_checker checker_i (.*);

	// output stall pattern is redrawn each time stall_phase runs out: none, light or heavy
	int stall_phase = 0;
	int stall_pct = 0;
	always @(negedge clk) begin
		if (stall_phase == 0) begin
			stall_phase = 200;
			stall_pct = $urandom_range(0, 2) * 35;
		end
		stall_phase--;
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	task automatic send(input lfbd_pkg::mode_t m, input logic [7:0] px,
			input logic [7:0] py, input logic [31:0] colours);
		int idle;
		if (burst_left == 0) begin
			in_valid = 1'b0;
			idle = $urandom_range(0, 6);
			repeat (idle) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		mode = m;
		x = px;
		y = py;
		{red, gray, blue, green} = colours;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic go_idle();
		in_valid = 1'b0;
		burst_left = 0;
		@(negedge clk);
	endtask

	// registers change only once all results are out and loads have drained
	task automatic write_reg(input lfbd_pkg::reg_idx_t idx, input logic [7:0] val);
		go_idle();
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] pick_colours();
		if ($urandom_range(0, 99) < blank_pct) return 32'd0;
		return $urandom();
	endfunction

	task automatic load_walk();
		int dx, dy;
		if ($urandom_range(0, 9) == 0) begin
			walk_x = 8'($urandom());
			walk_y = 8'($urandom());
		end else begin
			dx = $urandom_range(0, 2 * step_span) - step_span;
			dy = $urandom_range(0, 2 * step_span) - step_span;
			walk_x = 8'(int'(walk_x) + dx);
			walk_y = 8'(int'(walk_y) + dy);
		end
		send(lfbd_pkg::MODE_LOAD, walk_x, walk_y, pick_colours());
	endtask

	task automatic fetch_some(input int n);
		for (int i = 0; i < n; i++)
			send(lfbd_pkg::MODE_FETCH, 8'($urandom()), 8'($urandom()), $urandom());
	endtask

	initial begin
		int npts, nfetch, sel;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		write_reg(lfbd_pkg::REG_JUMP_THRESHOLD, 8'd25);
		write_reg(lfbd_pkg::REG_BASE_DISTANCE, 8'd3);

		// directed: idle fetches, empty frame, extremes, midpoints, repeats
		send(lfbd_pkg::MODE_FETCH, 8'd0, 8'd0, 32'd0);
		send(lfbd_pkg::MODE_NONE, 8'hff, 8'hff, 32'hffffffff);
		send(lfbd_pkg::MODE_END, 8'd0, 8'd0, 32'd0);
		send(lfbd_pkg::MODE_LOAD, 8'd0, 8'd0, 32'hffffffff);
		send(lfbd_pkg::MODE_LOAD, 8'd255, 8'd255, 32'h01020304);
		send(lfbd_pkg::MODE_LOAD, 8'd255, 8'd0, 32'h80000000);
		send(lfbd_pkg::MODE_LOAD, 8'd230, 8'd25, 32'd0);
		send(lfbd_pkg::MODE_LOAD, 8'd204, 8'd51, 32'h00000001);
		send(lfbd_pkg::MODE_LOAD, 8'd205, 8'd52, 32'h00ff00ff);
		send(lfbd_pkg::MODE_END, 8'd0, 8'd0, 32'd0);
		send(lfbd_pkg::MODE_END, 8'd0, 8'd0, 32'd0);
		fetch_some(3);
		send(lfbd_pkg::MODE_END, 8'd0, 8'd0, 32'd0);
		fetch_some(2);
		send(lfbd_pkg::MODE_LOAD, 8'd100, 8'd100, 32'h55aa55aa);
		send(lfbd_pkg::MODE_LOAD, 8'd101, 8'd99, 32'haa55aa55);
		send(lfbd_pkg::MODE_END, 8'd0, 8'd0, 32'd0);
		fetch_some(FRAME_POINTS + 2);

		// blank points only: nothing can be thinned, frame is dropped
		write_reg(lfbd_pkg::REG_JUMP_THRESHOLD, 8'd255);
		blank_pct = 100;
		step_span = 2;
		for (int i = 0; i < 300; i++) load_walk();
		send(lfbd_pkg::MODE_END, 8'd0, 8'd0, 32'd0);

		while (items_sent < ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				sel = $urandom_range(0, 3);
				write_reg(lfbd_pkg::REG_JUMP_THRESHOLD, sel == 0 ? 8'd0 : sel == 1 ? 8'd255 :
					8'($urandom_range(0, 60)));
				sel = $urandom_range(0, 3);
				write_reg(lfbd_pkg::REG_BASE_DISTANCE, sel == 0 ? 8'd0 : sel == 1 ? 8'd255 :
					8'($urandom_range(0, 12)));
			end
			step_span = $urandom_range(0, 2) == 0 ? 2 : $urandom_range(3, 40);
			blank_pct = $urandom_range(0, 40);
			sel = $urandom_range(0, 99);
			npts = sel < 80 ? $urandom_range(1, 60) : $urandom_range(271, 700);
			for (int i = 0; i < npts && items_sent < ITEMS; i++) begin
				if ($urandom_range(0, 29) == 0)
					send($urandom_range(0, 1) ? lfbd_pkg::MODE_FETCH : lfbd_pkg::MODE_NONE,
						8'($urandom()), 8'($urandom()), $urandom());
				load_walk();
			end
			if ($urandom_range(0, 9) != 0) send(lfbd_pkg::MODE_END, 8'd0, 8'd0, 32'd0);
			nfetch = $urandom_range(0, 3) != 0 ? FRAME_POINTS : $urandom_range(0, 300);
			fetch_some(nfetch);
			if ($urandom_range(0, 7) == 0) begin
				send(lfbd_pkg::MODE_END, 8'd0, 8'd0, 32'd0);
				fetch_some($urandom_range(0, 20));
			end
		end

		go_idle();
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (fail_count == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

	initial begin
		#200000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== laser_frame_blank_decimate_core.f =====
rtl/core/lfbd_pkg.sv
rtl/core/lfbd_store.sv
rtl/core/laser_frame_blank_decimate_core.sv
sim/lfbd_checker.sv
sim/tb.sv
